// ===== rtl/bfu_pkg.sv =====
package bfu_pkg;

    // frame geometry and fraction precision
    localparam int SRC_COLS  = 32;
    localparam int SRC_ROWS  = 24;
    localparam int DST_COLS  = 320;
    localparam int DST_ROWS  = 240;
    localparam int FRAC_BITS = 8;

    // fixed field widths of the item and result
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 10;
    localparam int X_W      = 9;
    localparam int Y_W      = 8;

    // op codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // frame store
    localparam int DEPTH  = SRC_ROWS * SRC_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    // source and saturated destination index widths
    localparam int XI_W = $clog2(SRC_COLS);
    localparam int YI_W = $clog2(SRC_ROWS);
    localparam int DX_W = $clog2(DST_COLS);
    localparam int DY_W = $clog2(DST_ROWS);

    // horizontal mapping: v = dest * (SRC-1) * 2^F / (DST-1), by reciprocal multiply
    localparam longint KX_L   = longint'(SRC_COLS - 1) << FRAC_BITS;
    localparam longint DENX_L = longint'(DST_COLS - 1);
    localparam int     NX_W   = $clog2(DENX_L * KX_L + 1);
    localparam longint MX_L   = (longint'(1) << NX_W) / DENX_L;
    localparam int     MX_W   = $clog2(MX_L + 1);
    localparam int     VX_W   = $clog2(KX_L + 1);
    localparam logic [NX_W-1:0] KX_C   = NX_W'(KX_L);
    localparam logic [NX_W-1:0] DENX_C = NX_W'(DENX_L);
    localparam logic [MX_W-1:0] MX_C   = MX_W'(MX_L);

    // vertical mapping, same scheme
    localparam longint KY_L   = longint'(SRC_ROWS - 1) << FRAC_BITS;
    localparam longint DENY_L = longint'(DST_ROWS - 1);
    localparam int     NY_W   = $clog2(DENY_L * KY_L + 1);
    localparam longint MY_L   = (longint'(1) << NY_W) / DENY_L;
    localparam int     MY_W   = $clog2(MY_L + 1);
    localparam int     VY_W   = $clog2(KY_L + 1);
    localparam logic [NY_W-1:0] KY_C   = NY_W'(KY_L);
    localparam logic [NY_W-1:0] DENY_C = NY_W'(DENY_L);
    localparam logic [MY_W-1:0] MY_C   = MY_W'(MY_L);

    // blend arithmetic
    localparam int W_W    = 2 * FRAC_BITS + 1;
    localparam int PROD_W = SAMPLE_W + W_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic [FRAC_BITS:0] ONE_C = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] RES_MIN = ~RES_MAX;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                       op;
        logic [INDEX_W-1:0]         src_index;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [X_W-1:0]             dest_x;
        logic [Y_W-1:0]             dest_y;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] interp_value;
        logic [X_W-1:0]             out_x;
        logic [Y_W-1:0]             out_y;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                       is_query;
        logic                       wr_en;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] value;
        logic [DX_W-1:0]            dx;
        logic [DY_W-1:0]            dy;
        logic [X_W-1:0]             raw_x;
        logic [Y_W-1:0]             raw_y;
    } cmd_t;

endpackage

// ===== rtl/bilinear_frame_upscaler_unit.sv =====
// A query's result passes from the queue through stages a to f and the output register.
// Throughput: one item per cycle while the result is not held; the queue and a fully pipelined back end (seven
// register stages, four store copies read in parallel) set this figure.
// Writes give no result and reach the frame store from stage d, in item order.
// Reset (rst_n, asynchronous, active low) empties the queue and the pipeline;
// the frame store is not cleared and holds nothing defined until written.
module bilinear_frame_upscaler_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  bfu_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output bfu_pkg::out_item_t result
);
    import bfu_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic take;

    // classify and queue
    bfu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .take       (take)
    );

    // mapping, store access and blend
    bfu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // back end only takes from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n) take |-> cmd_valid)
        else $error("back end took from an empty queue");

    // a held result freezes the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !take)
        else $error("back end took an item while the result was held");

    // a full queue always has an item to hand on
    assert property (@(posedge clk) disable iff (!rst_n) item_stall |-> cmd_valid)
        else $error("input stalled with an empty queue");

    // a result that was held stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("held result dropped");

endmodule

// ===== rtl/bfu_ram.sv =====
module bfu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bfu_front.sv =====
module bfu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  bfu_pkg::in_item_t  item,
    output logic               cmd_valid,
    output bfu_pkg::cmd_t      cmd,
    input  logic               take
);
    import bfu_pkg::*;

    cmd_t              cls;
    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    // classify the incoming item
    always_comb
    begin
        cls.is_query = (item.op == OP_QUERY);
        cls.wr_en    = (item.op == OP_WRITE) && (32'(item.src_index) < DEPTH);
        cls.addr     = ADDR_W'(item.src_index);
        cls.value    = item.sample_value;
        cls.dx       = (32'(item.dest_x) >= DST_COLS) ? DX_W'(DST_COLS - 1)
                                                      : DX_W'(item.dest_x);
        cls.dy       = (32'(item.dest_y) >= DST_ROWS) ? DY_W'(DST_ROWS - 1)
                                                      : DY_W'(item.dest_y);
        cls.raw_x    = item.dest_x;
        cls.raw_y    = item.dest_y;
    end

    // queue handshake
    assign item_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push       = item_valid && !item_stall;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = q_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/bfu_back.sv =====
module bfu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  bfu_pkg::cmd_t      cmd,
    output logic               take,
    output logic               result_valid,
    input  logic               result_stall,
    output bfu_pkg::out_item_t result
);
    import bfu_pkg::*;

    logic adv;

    // stage a: scaled positions
    logic            a_vld_reg;
    cmd_t            a_cmd_reg;
    logic [NX_W-1:0] a_nx_reg, a_nx_next;
    logic [NY_W-1:0] a_ny_reg, a_ny_next;

    // stage b: quotient estimates
    logic                 b_vld_reg;
    cmd_t                 b_cmd_reg;
    logic [NX_W-1:0]      b_nx_reg;
    logic [NY_W-1:0]      b_ny_reg;
    logic [NX_W+MX_W-1:0] b_px;
    logic [NY_W+MY_W-1:0] b_py;
    logic [VX_W-1:0]      b_qx_reg, b_qx_next;
    logic [VY_W-1:0]      b_qy_reg, b_qy_next;

    // stage c: corrected indices and fractions
    logic                 c_vld_reg;
    cmd_t                 c_cmd_reg;
    logic [NX_W-1:0]      c_rx;
    logic [NY_W-1:0]      c_ry;
    logic [VX_W-1:0]      c_vx;
    logic [VY_W-1:0]      c_vy;
    logic [XI_W-1:0]      c_x1_reg, c_x1_next, c_x2_reg, c_x2_next;
    logic [YI_W-1:0]      c_y1_reg, c_y1_next, c_y2_reg, c_y2_next;
    logic [FRAC_BITS-1:0] c_fx_reg, c_fx_next, c_fy_reg, c_fy_next;

    // stage d: addresses and weights
    logic              d_vld_reg;
    cmd_t              d_cmd_reg;
    logic [FRAC_BITS:0] d_ix, d_iy;
    logic [ADDR_W-1:0] d_addr_reg [4];
    logic [ADDR_W-1:0] d_addr_next [4];
    logic [W_W-1:0]    d_w_reg [4];
    logic [W_W-1:0]    d_w_next [4];
    logic              ram_we;

    // stage e: samples out of the store
    logic          e_vld_reg;
    logic          e_query_reg;
    logic [X_W-1:0] e_x_reg;
    logic [Y_W-1:0] e_y_reg;
    logic [W_W-1:0] e_w_reg [4];
    logic [SAMPLE_W-1:0] e_sample [4];

    // stage f: weighted samples
    logic                     f_vld_reg;
    logic                     f_query_reg;
    logic [X_W-1:0]           f_x_reg;
    logic [Y_W-1:0]           f_y_reg;
    logic signed [PROD_W-1:0] f_p_reg [4];
    logic signed [PROD_W-1:0] f_p_next [4];

    // output register
    logic                    out_vld_reg, out_vld_next;
    out_item_t               out_reg, out_next;
    logic signed [ACC_W-1:0] g_sum, g_sh;

    // pipeline moves whenever the output register can take a new value
    assign adv  = !out_vld_reg || !result_stall;
    assign take = adv && cmd_valid;

    // stage a logic
    always_comb
    begin
        a_nx_next = NX_W'(cmd.dx) * KX_C;
        a_ny_next = NY_W'(cmd.dy) * KY_C;
    end

    // stage b logic: reciprocal multiply, estimate is exact or one low
    always_comb
    begin
        b_px      = (NX_W + MX_W)'(a_nx_reg) * (NX_W + MX_W)'(MX_C);
        b_py      = (NY_W + MY_W)'(a_ny_reg) * (NY_W + MY_W)'(MY_C);
        b_qx_next = b_px[NX_W +: VX_W];
        b_qy_next = b_py[NY_W +: VY_W];
    end

    // stage c logic: remainder check, split into index and fraction
    always_comb
    begin
        c_rx = b_nx_reg - NX_W'(b_qx_reg) * DENX_C;
        c_ry = b_ny_reg - NY_W'(b_qy_reg) * DENY_C;
        c_vx = (c_rx >= DENX_C) ? b_qx_reg + 1'b1 : b_qx_reg;
        c_vy = (c_ry >= DENY_C) ? b_qy_reg + 1'b1 : b_qy_reg;
        c_x1_next = XI_W'(c_vx >> FRAC_BITS);
        c_y1_next = YI_W'(c_vy >> FRAC_BITS);
        c_fx_next = c_vx[FRAC_BITS-1:0];
        c_fy_next = c_vy[FRAC_BITS-1:0];
        // second neighbor clamps at the last column and row
        c_x2_next = (c_x1_next == XI_W'(SRC_COLS - 1)) ? c_x1_next : c_x1_next + 1'b1;
        c_y2_next = (c_y1_next == YI_W'(SRC_ROWS - 1)) ? c_y1_next : c_y1_next + 1'b1;
    end

    // stage d logic
    always_comb
    begin
        d_ix = ONE_C - (FRAC_BITS + 1)'(c_fx_reg);
        d_iy = ONE_C - (FRAC_BITS + 1)'(c_fy_reg);
        d_addr_next[0] = ADDR_W'(c_y1_reg) * ADDR_W'(SRC_COLS) + ADDR_W'(c_x1_reg);
        d_addr_next[1] = ADDR_W'(c_y1_reg) * ADDR_W'(SRC_COLS) + ADDR_W'(c_x2_reg);
        d_addr_next[2] = ADDR_W'(c_y2_reg) * ADDR_W'(SRC_COLS) + ADDR_W'(c_x1_reg);
        d_addr_next[3] = ADDR_W'(c_y2_reg) * ADDR_W'(SRC_COLS) + ADDR_W'(c_x2_reg);
        d_w_next[0]    = W_W'(d_ix) * W_W'(d_iy);
        d_w_next[1]    = W_W'(c_fx_reg) * W_W'(d_iy);
        d_w_next[2]    = W_W'(d_ix) * W_W'(c_fy_reg);
        d_w_next[3]    = W_W'(c_fx_reg) * W_W'(c_fy_reg);
    end

    // writes reach the store in item order, at the point where queries read it
    assign ram_we = adv && d_vld_reg && d_cmd_reg.wr_en;

    // one store copy per neighbor, all written alike
    for (genvar i = 0; i < 4; i++)
    begin : g_store
        bfu_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (d_cmd_reg.addr),
            .wdata (d_cmd_reg.value),
            .re    (adv),
            .raddr (d_addr_reg[i]),
            .rdata (e_sample[i])
        );
    end

    // stage f logic: sample times weight
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            f_p_next[i] = $signed(e_sample[i]) * $signed({1'b0, e_w_reg[i]});
        end
    end

    // output logic: sum, floor shift, saturate
    always_comb
    begin
        g_sum = ACC_W'(f_p_reg[0]) + ACC_W'(f_p_reg[1])
              + ACC_W'(f_p_reg[2]) + ACC_W'(f_p_reg[3]);
        g_sh  = g_sum >>> (2 * FRAC_BITS);
        out_next.out_x = f_x_reg;
        out_next.out_y = f_y_reg;
        if (g_sh > RES_MAX)
        begin
            out_next.interp_value = SAMPLE_W'(RES_MAX);
        end
        else if (g_sh < RES_MIN)
        begin
            out_next.interp_value = SAMPLE_W'(RES_MIN);
        end
        else
        begin
            out_next.interp_value = SAMPLE_W'(g_sh);
        end
        out_vld_next = f_vld_reg && f_query_reg;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= cmd_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            out_vld_reg <= out_vld_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cmd_reg   <= cmd;
            a_nx_reg    <= a_nx_next;
            a_ny_reg    <= a_ny_next;
            b_cmd_reg   <= a_cmd_reg;
            b_nx_reg    <= a_nx_reg;
            b_ny_reg    <= a_ny_reg;
            b_qx_reg    <= b_qx_next;
            b_qy_reg    <= b_qy_next;
            c_cmd_reg   <= b_cmd_reg;
            c_x1_reg    <= c_x1_next;
            c_x2_reg    <= c_x2_next;
            c_y1_reg    <= c_y1_next;
            c_y2_reg    <= c_y2_next;
            c_fx_reg    <= c_fx_next;
            c_fy_reg    <= c_fy_next;
            d_cmd_reg   <= c_cmd_reg;
            d_addr_reg  <= d_addr_next;
            d_w_reg     <= d_w_next;
            e_query_reg <= d_cmd_reg.is_query;
            e_x_reg     <= d_cmd_reg.raw_x;
            e_y_reg     <= d_cmd_reg.raw_y;
            e_w_reg     <= d_w_reg;
            f_query_reg <= e_query_reg;
            f_x_reg     <= e_x_reg;
            f_y_reg     <= e_y_reg;
            f_p_reg     <= f_p_next;
            out_reg     <= out_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule
